@@ design/oplsq_pkg.sv @@
// Shared types, constants and saturating fixed-point helpers for the
// orthogonal polynomial least-squares fit block. No dependencies.
package oplsq_pkg;

  localparam int MAX_SAMPLES_DEF = 256;
  localparam int MAX_DEGREE_DEF  = 5;

  localparam logic [63:0] Q_ONE   = 64'h0000_0001_0000_0000;
  localparam logic [63:0] Q_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] Q_MIN   = 64'h8000_0000_0000_0000;
  localparam logic [62:0] TOL_RST = 63'd4294967;

  // Arithmetic unit operations
  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV
  } alu_op_t;

  // Request from the sequencer to the arithmetic unit
  typedef struct packed {
    logic        go;
    alu_op_t     op;
    logic [63:0] a;
    logic [63:0] b;
  } alu_req_t;

  // Magnitude of a two's complement value (most negative gives 2^63)
  function automatic logic [63:0] mag_of(input logic [63:0] a);
    return a[63] ? (64'd0 - a) : a;
  endfunction

  // Signed value from sign and magnitude, saturated
  function automatic logic [63:0] from_mag(input logic neg, input logic [63:0] m);
    logic [63:0] r;
    if (neg) begin
      r = m[63] ? Q_MIN : (64'd0 - m);
    end else begin
      r = m[63] ? Q_MAX : m;
    end
    return r;
  endfunction

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    logic [63:0] r;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      r = s[64] ? Q_MIN : Q_MAX;
    end else begin
      r = s[63:0];
    end
    return r;
  endfunction

  function automatic logic [63:0] sat_sub(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    logic [63:0] r;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) begin
      r = s[64] ? Q_MIN : Q_MAX;
    end else begin
      r = s[63:0];
    end
    return r;
  endfunction

endpackage

@@ design/oplsq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module oplsq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/oplsq_alu.sv @@
// Shared Q32.32 arithmetic unit: saturating add/sub, multiply from
// four 32x32 partial products, restoring divide one bit per cycle. Uses oplsq_pkg.
module oplsq_alu (
  input  logic                clk,
  input  logic                rst_n,
  input  oplsq_pkg::alu_req_t req,
  output logic                done,
  output logic [63:0]         res
);
  import oplsq_pkg::*;

  typedef enum logic [1:0] {
    A_IDLE,
    A_MUL,
    A_DIV
  } ast_t;

  localparam logic [2:0] STEP_LAST_PP = 3'd3;
  localparam logic [2:0] STEP_LAST_AD = 3'd4;
  localparam logic [6:0] DIV_FIRST    = 7'd95;
  localparam logic [6:0] DIV_SAT_BIT  = 7'd63;

  ast_t          st_r, st_nxt;
  logic          done_r, done_nxt;
  logic [63:0]   res_r, res_nxt;
  logic          neg_r, neg_nxt;
  logic [63:0]   ua_r, ua_nxt, ub_r, ub_nxt;
  logic [127:0]  acc_r, acc_nxt;
  logic [63:0]   pp_r, pp_nxt;
  logic [2:0]    step_r, step_nxt;
  logic [95:0]   dvd_r, dvd_nxt;
  logic [63:0]   rem_r, rem_nxt;
  logic [63:0]   d_r, d_nxt;
  logic [62:0]   q_r, q_nxt;
  logic [6:0]    cnt_r, cnt_nxt;

  logic [31:0]   ma, mb;
  logic [63:0]   pp_w;
  logic [127:0]  addend;
  logic [64:0]   r2, diff;
  logic          ge;
  logic [62:0]   q_w;

  // Partial product select and alignment
  always_comb begin
    case (step_r)
      3'd0:    begin ma = ua_r[31:0];  mb = ub_r[31:0];  end
      3'd1:    begin ma = ua_r[31:0];  mb = ub_r[63:32]; end
      3'd2:    begin ma = ua_r[63:32]; mb = ub_r[31:0];  end
      default: begin ma = ua_r[63:32]; mb = ub_r[63:32]; end
    endcase
    case (step_r)
      3'd1:       addend = {64'd0, pp_r};
      3'd2, 3'd3: addend = {32'd0, pp_r, 32'd0};
      default:    addend = {pp_r, 64'd0};
    endcase
  end

  assign pp_w = ma * mb;

  // Restoring divide step
  assign r2   = {rem_r, dvd_r[95]};
  assign ge   = r2 >= {1'b0, d_r};
  assign diff = r2 - {1'b0, d_r};
  assign q_w  = {q_r[61:0], ge};

  always_comb begin
    st_nxt   = st_r;
    done_nxt = 1'b0;
    res_nxt  = res_r;
    neg_nxt  = neg_r;
    ua_nxt   = ua_r;
    ub_nxt   = ub_r;
    acc_nxt  = acc_r;
    pp_nxt   = pp_r;
    step_nxt = step_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    case (st_r)
      A_IDLE: begin
        if (req.go) begin
          case (req.op)
            OP_ADD: begin
              res_nxt  = sat_add(req.a, req.b);
              done_nxt = 1'b1;
            end
            OP_SUB: begin
              res_nxt  = sat_sub(req.a, req.b);
              done_nxt = 1'b1;
            end
            OP_MUL: begin
              neg_nxt  = req.a[63] ^ req.b[63];
              ua_nxt   = mag_of(req.a);
              ub_nxt   = mag_of(req.b);
              // rounding constant preloaded
              acc_nxt  = 128'h8000_0000;
              step_nxt = 3'd0;
              st_nxt   = A_MUL;
            end
            OP_DIV: begin
              if (req.b == 64'd0) begin
                if (req.a == 64'd0) begin
                  res_nxt = 64'd0;
                end else begin
                  res_nxt = req.a[63] ? Q_MIN : Q_MAX;
                end
                done_nxt = 1'b1;
              end else begin
                neg_nxt = req.a[63] ^ req.b[63];
                d_nxt   = mag_of(req.b);
                dvd_nxt = {mag_of(req.a), 32'd0};
                rem_nxt = 64'd0;
                q_nxt   = 63'd0;
                cnt_nxt = DIV_FIRST;
                st_nxt  = A_DIV;
              end
            end
            default: begin
              done_nxt = 1'b1;
            end
          endcase
        end
      end
      A_MUL: begin
        if (step_r <= STEP_LAST_PP) begin
          pp_nxt = pp_w;
        end
        if (step_r != 3'd0 && step_r <= STEP_LAST_AD) begin
          acc_nxt = acc_r + addend;
        end
        step_nxt = step_r + 3'd1;
        if (step_r > STEP_LAST_AD) begin
          if (acc_r[127:96] != 32'd0) begin
            res_nxt = neg_r ? Q_MIN : Q_MAX;
          end else begin
            res_nxt = from_mag(neg_r, acc_r[95:32]);
          end
          done_nxt = 1'b1;
          st_nxt   = A_IDLE;
        end
      end
      A_DIV: begin
        dvd_nxt = {dvd_r[94:0], 1'b0};
        cnt_nxt = cnt_r - 7'd1;
        rem_nxt = ge ? diff[63:0] : r2[63:0];
        if (ge && cnt_r >= DIV_SAT_BIT) begin
          res_nxt  = neg_r ? Q_MIN : Q_MAX;
          done_nxt = 1'b1;
          st_nxt   = A_IDLE;
        end else begin
          q_nxt = q_w;
          if (cnt_r == 7'd0) begin
            res_nxt  = from_mag(neg_r, {1'b0, q_w});
            done_nxt = 1'b1;
            st_nxt   = A_IDLE;
          end
        end
      end
      default: begin
        st_nxt = A_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= A_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
    end
    res_r  <= res_nxt;
    neg_r  <= neg_nxt;
    ua_r   <= ua_nxt;
    ub_r   <= ub_nxt;
    acc_r  <= acc_nxt;
    pp_r   <= pp_nxt;
    step_r <= step_nxt;
    dvd_r  <= dvd_nxt;
    rem_r  <= rem_nxt;
    d_r    <= d_nxt;
    q_r    <= q_nxt;
    cnt_r  <= cnt_nxt;
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

@@ design/oplsq_seq.sv @@
// Fit sequencer: sample intake, sample passes, recurrence and result output,
// issuing every operation to the shared arithmetic unit. Uses oplsq_pkg.
module oplsq_seq #(
  parameter int MAX_SAMPLES = oplsq_pkg::MAX_SAMPLES_DEF,
  parameter int MAX_DEGREE  = oplsq_pkg::MAX_DEGREE_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic                           in_last_sample,
  output logic                           busy,
  input  logic                           cfg_valid,
  input  logic [62:0]                    cfg_data,
  output logic                           mem_we,
  output logic [$clog2(MAX_SAMPLES)-1:0] mem_waddr,
  output logic [$clog2(MAX_SAMPLES)-1:0] mem_raddr,
  input  logic [31:0]                    x_rd,
  input  logic [31:0]                    w_rd,
  input  logic [31:0]                    y_rd,
  output oplsq_pkg::alu_req_t            alu_req,
  input  logic                           alu_done,
  input  logic [63:0]                    alu_res,
  output logic                           out_strobe,
  output logic [2:0]                     out_coeff_index,
  output logic [63:0]                    out_coefficient,
  output logic [2:0]                     out_fit_degree,
  output logic [63:0]                    out_residual,
  output logic                           out_last_coeff
);
  import oplsq_pkg::*;

  localparam int AW = $clog2(MAX_SAMPLES);
  localparam int CW = $clog2(MAX_SAMPLES + 1);
  localparam int NP = MAX_DEGREE + 1;
  localparam int JW = $clog2(NP);
  localparam logic [JW-1:0] J_TOP = JW'(MAX_DEGREE);

  typedef enum logic [6:0] {
    S_IDLE, S_INIT, S_WAIT, S_OUT, S_CHK,
    S_F1, S_P1A, S_P1B, S_P1C, S_P1D, S_P1E, S_P1F, S_P1G, S_P1H,
    S_D1A, S_D1B, S_D1C, S_D1D, S_D1E,
    S_F2, S_P2A, S_P2B, S_P2C, S_P2D, S_P2E, S_P2F, S_P2G, S_P2H,
    S_A1A, S_A1B, S_A1C, S_A1D, S_A1E, S_A1F, S_A1G,
    S_F3, S_P3A, S_P3B, S_P3C, S_P3D, S_P3E, S_P3F, S_P3G, S_P3H,
    S_P3I, S_P3J, S_P3K, S_P3L, S_P3M,
    S_R1A, S_R1B, S_R1C, S_R1D, S_R1E, S_R1F, S_R1G, S_R1H,
    S_F4, S_P4A, S_P4B, S_P4C, S_P4D, S_P4E, S_P4F, S_P4G,
    S_H0, S_H1, S_H2, S_H3
  } st_t;

  typedef enum logic [1:0] {
    PS_PREV,
    PS_CURR,
    PS_NEXT
  } psel_t;

  st_t            st_r, st_nxt, ret_r, ret_nxt, hret_r, hret_nxt;
  psel_t          hsel_r, hsel_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt, i_r, i_nxt;
  logic [JW-1:0]  j_r, j_nxt, k_r, k_nxt;
  logic           first_r, first_nxt;
  logic [62:0]    tol_r, tol_nxt;
  // acc0..acc3 hold the running inner products of the current pass
  logic [63:0]    acc0_r, acc0_nxt, acc1_r, acc1_nxt, acc2_r, acc2_nxt, acc3_r, acc3_nxt;
  logic [63:0]    alpha_r, alpha_nxt, beta_r, beta_nxt, a_r, a_nxt, err_r, err_nxt;
  logic [63:0]    t0_r, t0_nxt, t1_r, t1_nxt, hv_r, hv_nxt;
  logic [63:0]    prev_r [NP];
  logic [63:0]    prev_nxt [NP];
  logic [63:0]    curr_r [NP];
  logic [63:0]    curr_nxt [NP];
  logic [63:0]    next_r [NP];
  logic [63:0]    next_nxt [NP];
  logic [63:0]    coeff_r [NP];
  logic [63:0]    coeff_nxt [NP];
  logic           strobe_r, strobe_nxt, olast_r, olast_nxt;
  logic [2:0]     oidx_r, oidx_nxt, odeg_r, odeg_nxt;
  logic [63:0]    ocoef_r, ocoef_nxt, ores_r, ores_nxt;

  logic           go;
  alu_op_t        op;
  logic [63:0]    oa, ob;
  st_t            rs;
  logic [63:0]    xq, wq, yq, p_top, p_j;

  // Samples widened to Q32.32
  assign xq = {{16{x_rd[31]}}, x_rd, 16'd0};
  assign yq = {{16{y_rd[31]}}, y_rd, 16'd0};
  assign wq = {16'd0, w_rd, 16'd0};

  // Polynomial read port for Horner evaluation
  always_comb begin
    case (hsel_r)
      PS_PREV: begin p_top = prev_r[MAX_DEGREE]; p_j = prev_r[j_r]; end
      PS_CURR: begin p_top = curr_r[MAX_DEGREE]; p_j = curr_r[j_r]; end
      default: begin p_top = next_r[MAX_DEGREE]; p_j = next_r[j_r]; end
    endcase
  end

  // Sequencer next state
  always_comb begin
    st_nxt    = st_r;
    ret_nxt   = ret_r;
    hret_nxt  = hret_r;
    hsel_nxt  = hsel_r;
    cnt_nxt   = cnt_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    first_nxt = first_r;
    tol_nxt   = tol_r;
    acc0_nxt  = acc0_r;
    acc1_nxt  = acc1_r;
    acc2_nxt  = acc2_r;
    acc3_nxt  = acc3_r;
    alpha_nxt = alpha_r;
    beta_nxt  = beta_r;
    a_nxt     = a_r;
    err_nxt   = err_r;
    t0_nxt    = t0_r;
    t1_nxt    = t1_r;
    hv_nxt    = hv_r;
    prev_nxt  = prev_r;
    curr_nxt  = curr_r;
    next_nxt  = next_r;
    coeff_nxt = coeff_r;
    strobe_nxt = 1'b0;
    olast_nxt = olast_r;
    oidx_nxt  = oidx_r;
    odeg_nxt  = odeg_r;
    ocoef_nxt = ocoef_r;
    ores_nxt  = ores_r;
    go        = 1'b0;
    op        = OP_ADD;
    oa        = 64'd0;
    ob        = 64'd0;
    rs        = S_IDLE;
    mem_we    = 1'b0;

    if (cfg_valid) begin
      tol_nxt = cfg_data;
    end

    case (st_r)
      S_IDLE: begin
        if (start) begin
          if (cnt_r < CW'(MAX_SAMPLES)) begin
            mem_we  = 1'b1;
            cnt_nxt = cnt_r + 1'b1;
          end
          if (in_last_sample) begin
            st_nxt = S_INIT;
          end
        end
      end
      S_INIT: begin
        for (int p = 0; p < NP; p++) begin
          prev_nxt[p]  = 64'd0;
          curr_nxt[p]  = 64'd0;
          next_nxt[p]  = 64'd0;
          coeff_nxt[p] = 64'd0;
        end
        prev_nxt[0] = Q_ONE;
        acc0_nxt  = 64'd0;
        acc1_nxt  = 64'd0;
        acc2_nxt  = 64'd0;
        acc3_nxt  = 64'd0;
        k_nxt     = JW'(1);
        first_nxt = 1'b1;
        i_nxt     = '0;
        st_nxt    = (cnt_r == '0) ? S_D1A : S_F1;
      end
      S_WAIT: begin
        if (alu_done) begin
          st_nxt = ret_r;
        end
      end

      // pass 1: sums of w, wy, wyy, wx
      S_F1: st_nxt = S_P1A;
      S_P1A: begin go = 1'b1; op = OP_MUL; oa = wq; ob = yq; rs = S_P1B; end
      S_P1B: begin
        t0_nxt = alu_res;
        go = 1'b1; op = OP_ADD; oa = acc0_r; ob = wq; rs = S_P1C;
      end
      S_P1C: begin
        acc0_nxt = alu_res;
        go = 1'b1; op = OP_ADD; oa = acc1_r; ob = t0_r; rs = S_P1D;
      end
      S_P1D: begin
        acc1_nxt = alu_res;
        go = 1'b1; op = OP_MUL; oa = t0_r; ob = yq; rs = S_P1E;
      end
      S_P1E: begin go = 1'b1; op = OP_ADD; oa = acc2_r; ob = alu_res; rs = S_P1F; end
      S_P1F: begin
        acc2_nxt = alu_res;
        go = 1'b1; op = OP_MUL; oa = wq; ob = xq; rs = S_P1G;
      end
      S_P1G: begin go = 1'b1; op = OP_ADD; oa = acc3_r; ob = alu_res; rs = S_P1H; end
      S_P1H: begin
        acc3_nxt = alu_res;
        i_nxt    = i_r + 1'b1;
        st_nxt   = (i_r + 1'b1 == cnt_r) ? S_D1A : S_F1;
      end

      // degree 0 coefficient, first alpha
      S_D1A: begin go = 1'b1; op = OP_DIV; oa = acc1_r; ob = acc0_r; rs = S_D1B; end
      S_D1B: begin
        coeff_nxt[0] = alu_res;
        go = 1'b1; op = OP_MUL; oa = alu_res; ob = acc1_r; rs = S_D1C;
      end
      S_D1C: begin go = 1'b1; op = OP_SUB; oa = acc2_r; ob = alu_res; rs = S_D1D; end
      S_D1D: begin
        err_nxt = alu_res;
        go = 1'b1; op = OP_DIV; oa = acc3_r; ob = acc0_r; rs = S_D1E;
      end
      S_D1E: begin
        alpha_nxt   = alu_res;
        // degree 1 polynomial is x - alpha
        curr_nxt[0] = from_mag(~alu_res[63], mag_of(alu_res));
        curr_nxt[1] = Q_ONE;
        next_nxt[0] = from_mag(~alu_res[63], mag_of(alu_res));
        next_nxt[1] = Q_ONE;
        acc1_nxt    = 64'd0;
        acc2_nxt    = 64'd0;
        i_nxt       = '0;
        st_nxt      = (cnt_r == '0) ? S_A1A : S_F2;
      end

      // pass 2: projections on the degree 1 polynomial
      S_F2: st_nxt = S_P2A;
      S_P2A: begin go = 1'b1; op = OP_SUB; oa = xq; ob = alpha_r; rs = S_P2B; end
      S_P2B: begin
        t0_nxt = alu_res;
        go = 1'b1; op = OP_MUL; oa = wq; ob = yq; rs = S_P2C;
      end
      S_P2C: begin go = 1'b1; op = OP_MUL; oa = alu_res; ob = t0_r; rs = S_P2D; end
      S_P2D: begin go = 1'b1; op = OP_ADD; oa = acc1_r; ob = alu_res; rs = S_P2E; end
      S_P2E: begin
        acc1_nxt = alu_res;
        go = 1'b1; op = OP_MUL; oa = t0_r; ob = t0_r; rs = S_P2F;
      end
      S_P2F: begin go = 1'b1; op = OP_MUL; oa = wq; ob = alu_res; rs = S_P2G; end
      S_P2G: begin go = 1'b1; op = OP_ADD; oa = acc2_r; ob = alu_res; rs = S_P2H; end
      S_P2H: begin
        acc2_nxt = alu_res;
        i_nxt    = i_r + 1'b1;
        st_nxt   = (i_r + 1'b1 == cnt_r) ? S_A1A : S_F2;
      end

      // apply coefficient of the newest polynomial
      S_A1A: begin go = 1'b1; op = OP_DIV; oa = acc1_r; ob = acc2_r; rs = S_A1B; end
      S_A1B: begin
        a_nxt = alu_res;
        go = 1'b1; op = OP_MUL; oa = alu_res; ob = acc1_r; rs = S_A1C;
      end
      S_A1C: begin go = 1'b1; op = OP_SUB; oa = err_r; ob = alu_res; rs = S_A1D; end
      S_A1D: begin
        err_nxt = alu_res;
        j_nxt   = '0;
        st_nxt  = S_A1E;
      end
      S_A1E: begin go = 1'b1; op = OP_MUL; oa = a_r; ob = next_r[j_r]; rs = S_A1F; end
      S_A1F: begin go = 1'b1; op = OP_ADD; oa = coeff_r[j_r]; ob = alu_res; rs = S_A1G; end
      S_A1G: begin
        coeff_nxt[j_r] = alu_res;
        if (j_r == J_TOP) begin
          if (!first_r) begin
            prev_nxt = curr_r;
            curr_nxt = next_r;
          end
          first_nxt = 1'b0;
          st_nxt    = S_CHK;
        end else begin
          j_nxt  = j_r + 1'b1;
          st_nxt = S_A1E;
        end
      end

      // raise the degree or finish
      S_CHK: begin
        if (k_r < J_TOP && mag_of(err_r) >= {1'b0, tol_r}) begin
          k_nxt    = k_r + 1'b1;
          acc0_nxt = 64'd0;
          acc2_nxt = 64'd0;
          acc3_nxt = 64'd0;
          i_nxt    = '0;
          st_nxt   = (cnt_r == '0) ? S_R1A : S_F3;
        end else begin
          j_nxt  = '0;
          st_nxt = S_OUT;
        end
      end

      // pass 3: norms of prev and curr, x-weighted norm of curr
      S_F3: st_nxt = S_P3A;
      S_P3A: begin
        hsel_nxt = PS_PREV;
        hret_nxt = S_P3B;
        st_nxt   = S_H0;
      end
      S_P3B: begin
        t0_nxt   = hv_r;
        hsel_nxt = PS_CURR;
        hret_nxt = S_P3C;
        st_nxt   = S_H0;
      end
      S_P3C: begin
        t1_nxt = hv_r;
        go = 1'b1; op = OP_MUL; oa = wq; ob = hv_r; rs = S_P3D;
      end
      S_P3D: begin go = 1'b1; op = OP_MUL; oa = alu_res; ob = t1_r; rs = S_P3E; end
      S_P3E: begin go = 1'b1; op = OP_ADD; oa = acc0_r; ob = alu_res; rs = S_P3F; end
      S_P3F: begin
        acc0_nxt = alu_res;
        go = 1'b1; op = OP_MUL; oa = wq; ob = xq; rs = S_P3G;
      end
      S_P3G: begin go = 1'b1; op = OP_MUL; oa = alu_res; ob = t1_r; rs = S_P3H; end
      S_P3H: begin go = 1'b1; op = OP_MUL; oa = alu_res; ob = t1_r; rs = S_P3I; end
      S_P3I: begin go = 1'b1; op = OP_ADD; oa = acc3_r; ob = alu_res; rs = S_P3J; end
      S_P3J: begin
        acc3_nxt = alu_res;
        go = 1'b1; op = OP_MUL; oa = wq; ob = t0_r; rs = S_P3K;
      end
      S_P3K: begin go = 1'b1; op = OP_MUL; oa = alu_res; ob = t0_r; rs = S_P3L; end
      S_P3L: begin go = 1'b1; op = OP_ADD; oa = acc2_r; ob = alu_res; rs = S_P3M; end
      S_P3M: begin
        acc2_nxt = alu_res;
        i_nxt    = i_r + 1'b1;
        st_nxt   = (i_r + 1'b1 == cnt_r) ? S_R1A : S_F3;
      end

      // three-term recurrence for the next polynomial
      S_R1A: begin go = 1'b1; op = OP_DIV; oa = acc3_r; ob = acc0_r; rs = S_R1B; end
      S_R1B: begin
        alpha_nxt = alu_res;
        go = 1'b1; op = OP_DIV; oa = acc0_r; ob = acc2_r; rs = S_R1C;
      end
      S_R1C: begin
        beta_nxt = alu_res;
        j_nxt    = '0;
        t0_nxt   = 64'd0;
        st_nxt   = S_R1D;
      end
      S_R1D: begin go = 1'b1; op = OP_MUL; oa = alpha_r; ob = curr_r[j_r]; rs = S_R1E; end
      S_R1E: begin go = 1'b1; op = OP_SUB; oa = t0_r; ob = alu_res; rs = S_R1F; end
      S_R1F: begin
        t1_nxt = alu_res;
        go = 1'b1; op = OP_MUL; oa = beta_r; ob = prev_r[j_r]; rs = S_R1G;
      end
      S_R1G: begin go = 1'b1; op = OP_SUB; oa = t1_r; ob = alu_res; rs = S_R1H; end
      S_R1H: begin
        next_nxt[j_r] = alu_res;
        // shifted-by-x term for the next index
        t0_nxt        = curr_r[j_r];
        if (j_r == J_TOP) begin
          acc1_nxt = 64'd0;
          acc2_nxt = 64'd0;
          i_nxt    = '0;
          st_nxt   = (cnt_r == '0) ? S_A1A : S_F4;
        end else begin
          j_nxt  = j_r + 1'b1;
          st_nxt = S_R1D;
        end
      end

      // pass 4: projections on the new polynomial
      S_F4: st_nxt = S_P4A;
      S_P4A: begin
        hsel_nxt = PS_NEXT;
        hret_nxt = S_P4B;
        st_nxt   = S_H0;
      end
      S_P4B: begin
        t1_nxt = hv_r;
        go = 1'b1; op = OP_MUL; oa = wq; ob = hv_r; rs = S_P4C;
      end
      S_P4C: begin
        t0_nxt = alu_res;
        go = 1'b1; op = OP_MUL; oa = alu_res; ob = yq; rs = S_P4D;
      end
      S_P4D: begin go = 1'b1; op = OP_ADD; oa = acc1_r; ob = alu_res; rs = S_P4E; end
      S_P4E: begin
        acc1_nxt = alu_res;
        go = 1'b1; op = OP_MUL; oa = t0_r; ob = t1_r; rs = S_P4F;
      end
      S_P4F: begin go = 1'b1; op = OP_ADD; oa = acc2_r; ob = alu_res; rs = S_P4G; end
      S_P4G: begin
        acc2_nxt = alu_res;
        i_nxt    = i_r + 1'b1;
        st_nxt   = (i_r + 1'b1 == cnt_r) ? S_A1A : S_F4;
      end

      // Horner evaluation of the selected polynomial at x
      S_H0: begin
        hv_nxt = p_top;
        j_nxt  = JW'(MAX_DEGREE - 1);
        st_nxt = S_H1;
      end
      S_H1: begin go = 1'b1; op = OP_MUL; oa = hv_r; ob = xq; rs = S_H2; end
      S_H2: begin go = 1'b1; op = OP_ADD; oa = alu_res; ob = p_j; rs = S_H3; end
      S_H3: begin
        hv_nxt = alu_res;
        if (j_r == '0) begin
          st_nxt = hret_r;
        end else begin
          j_nxt  = j_r - 1'b1;
          st_nxt = S_H1;
        end
      end

      // one result item per coefficient
      S_OUT: begin
        strobe_nxt = 1'b1;
        oidx_nxt   = 3'(j_r);
        ocoef_nxt  = coeff_r[j_r];
        odeg_nxt   = 3'(k_r);
        ores_nxt   = err_r;
        olast_nxt  = (j_r == J_TOP);
        if (j_r == J_TOP) begin
          cnt_nxt = '0;
          st_nxt  = S_IDLE;
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase

    if (go) begin
      st_nxt  = S_WAIT;
      ret_nxt = rs;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= S_IDLE;
      cnt_r    <= '0;
      tol_r    <= TOL_RST;
      strobe_r <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      cnt_r    <= cnt_nxt;
      tol_r    <= tol_nxt;
      strobe_r <= strobe_nxt;
    end
    ret_r   <= ret_nxt;
    hret_r  <= hret_nxt;
    hsel_r  <= hsel_nxt;
    i_r     <= i_nxt;
    j_r     <= j_nxt;
    k_r     <= k_nxt;
    first_r <= first_nxt;
    acc0_r  <= acc0_nxt;
    acc1_r  <= acc1_nxt;
    acc2_r  <= acc2_nxt;
    acc3_r  <= acc3_nxt;
    alpha_r <= alpha_nxt;
    beta_r  <= beta_nxt;
    a_r     <= a_nxt;
    err_r   <= err_nxt;
    t0_r    <= t0_nxt;
    t1_r    <= t1_nxt;
    hv_r    <= hv_nxt;
    prev_r  <= prev_nxt;
    curr_r  <= curr_nxt;
    next_r  <= next_nxt;
    coeff_r <= coeff_nxt;
    olast_r <= olast_nxt;
    oidx_r  <= oidx_nxt;
    odeg_r  <= odeg_nxt;
    ocoef_r <= ocoef_nxt;
    ores_r  <= ores_nxt;
  end

  assign busy      = (st_r != S_IDLE);
  assign mem_waddr = cnt_r[AW-1:0];
  assign mem_raddr = i_r[AW-1:0];
  assign alu_req   = '{go: go, op: op, a: oa, b: ob};

  assign out_strobe      = strobe_r;
  assign out_coeff_index = oidx_r;
  assign out_coefficient = ocoef_r;
  assign out_fit_degree  = odeg_r;
  assign out_residual    = ores_r;
  assign out_last_coeff  = olast_r;

endmodule

@@ design/orthogonal_poly_least_squares_top.sv @@
// Weighted least-squares polynomial fit by orthogonal polynomials, Q32.32.
// Depends on oplsq_pkg, oplsq_ram, oplsq_alu, oplsq_seq.
//
// Samples are taken one per clock while busy is low. The item with
// in_last_sample set is stored too and starts the fit. busy stays high until
// the last result is on the ports. The fit runs on one shared unit with a
// bit-serial divide. When the fit ends, MAX_DEGREE+1 results follow on
// consecutive cycles, each marked by out_strobe for one cycle; the receiver
// cannot hold them off. The tolerance register accepts a write in any cycle
// (cfg_ready is always high) and should be written only while busy is low.
module orthogonal_poly_least_squares_top #(
  parameter int MAX_SAMPLES = oplsq_pkg::MAX_SAMPLES_DEF,
  parameter int MAX_DEGREE  = oplsq_pkg::MAX_DEGREE_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_x_value,
  input  logic        [31:0] in_weight,
  input  logic signed [31:0] in_y_value,
  input  logic               in_last_sample,
  output logic               out_strobe,
  output logic        [2:0]  out_coeff_index,
  output logic signed [63:0] out_coefficient,
  output logic        [2:0]  out_fit_degree,
  output logic signed [63:0] out_residual,
  output logic               out_last_coeff,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic        [62:0] cfg_data
);
  import oplsq_pkg::*;

  localparam int AW = $clog2(MAX_SAMPLES);

  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [31:0]   x_rd, w_rd, y_rd;
  alu_req_t      alu_req;
  logic          alu_done;
  logic [63:0]   alu_res;
  logic [63:0]   coef_w, res_w;

  // Sample stores
  oplsq_ram #(.WIDTH(32), .DEPTH(MAX_SAMPLES)) u_x_ram (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(in_x_value),
    .raddr(mem_raddr), .rdata(x_rd)
  );
  oplsq_ram #(.WIDTH(32), .DEPTH(MAX_SAMPLES)) u_w_ram (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(in_weight),
    .raddr(mem_raddr), .rdata(w_rd)
  );
  oplsq_ram #(.WIDTH(32), .DEPTH(MAX_SAMPLES)) u_y_ram (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(in_y_value),
    .raddr(mem_raddr), .rdata(y_rd)
  );

  // Shared arithmetic unit
  oplsq_alu u_alu (
    .clk(clk), .rst_n(rst_n), .req(alu_req), .done(alu_done), .res(alu_res)
  );

  // Fit sequencer
  oplsq_seq #(.MAX_SAMPLES(MAX_SAMPLES), .MAX_DEGREE(MAX_DEGREE)) u_seq (
    .clk(clk), .rst_n(rst_n),
    .start(start), .in_last_sample(in_last_sample), .busy(busy),
    .cfg_valid(cfg_valid), .cfg_data(cfg_data),
    .mem_we(mem_we), .mem_waddr(mem_waddr), .mem_raddr(mem_raddr),
    .x_rd(x_rd), .w_rd(w_rd), .y_rd(y_rd),
    .alu_req(alu_req), .alu_done(alu_done), .alu_res(alu_res),
    .out_strobe(out_strobe), .out_coeff_index(out_coeff_index),
    .out_coefficient(coef_w), .out_fit_degree(out_fit_degree),
    .out_residual(res_w), .out_last_coeff(out_last_coeff)
  );

  assign out_coefficient = $signed(coef_w);
  assign out_residual    = $signed(res_w);
  assign cfg_ready       = 1'b1;

endmodule
